// ===== src/b64se_pkg.sv =====
// shared types, constants and the alphabet lookup for the base64 stream encoder
// no dependencies
`timescale 1ns / 1ps

package b64se_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0] PadChar = 8'h3D;
  localparam logic [1:0] MaxHeld = 2'd2;

  // one finished group as handed from the front to the back
  typedef struct packed {
    logic [23:0] bits24;
    logic [1:0]  present;
    logic        last;
  } grp_t;

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'(v) + 8'h41;
    end else if (v < 6'd52) begin
      c = 8'(v) - 8'd26 + 8'h61;
    end else if (v < 6'd62) begin
      c = 8'(v) - 8'd52 + 8'h30;
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

endpackage

// ===== src/b64se_front.sv =====
// input side: holds up to two bytes and packs finished groups
// depends on b64se_pkg
`timescale 1ns / 1ps

module b64se_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_tvalid_i,
  output logic               s_tready_o,
  input  logic [7:0]         s_tdata_i,
  input  logic               s_tlast_i,
  output logic               push_valid_o,
  input  logic               push_ready_i,
  output b64se_pkg::grp_t    push_data_o
);
  import b64se_pkg::*;

  logic [15:0] held_bytes_q, held_bytes_d;
  logic [1:0]  held_count_q, held_count_d;
  logic [1:0]  cnt;
  logic [1:0]  present;
  logic        accept;
  logic        emit;

  assign s_tready_o = push_ready_i;
  assign accept     = s_tvalid_i && s_tready_o;
  assign cnt        = (held_count_q > MaxHeld) ? MaxHeld : held_count_q;
  assign present    = cnt + 2'd1;
  assign emit       = s_tlast_i || (present == 2'd3);

  always_comb begin
    held_bytes_d = held_bytes_q;
    held_count_d = held_count_q;
    push_valid_o = 1'b0;
    push_data_o.present = present;
    push_data_o.last    = s_tlast_i;
    case (cnt)
      2'd0:    push_data_o.bits24 = {s_tdata_i, 16'h0000};
      2'd1:    push_data_o.bits24 = {held_bytes_q[7:0], s_tdata_i, 8'h00};
      default: push_data_o.bits24 = {held_bytes_q, s_tdata_i};
    endcase
    if (accept) begin
      if (emit) begin
        push_valid_o = 1'b1;
        held_bytes_d = 16'h0000;
        held_count_d = 2'd0;
      end else begin
        held_bytes_d = {held_bytes_q[7:0], s_tdata_i};
        held_count_d = present;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_bytes_q <= 16'h0000;
      held_count_q <= 2'd0;
    end else begin
      held_bytes_q <= held_bytes_d;
      held_count_q <= held_count_d;
    end
  end

endmodule

// ===== src/b64se_queue.sv =====
// short group queue between the front and the back
// depends on b64se_pkg
`timescale 1ns / 1ps

module b64se_queue #(
  parameter int unsigned Depth = b64se_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  b64se_pkg::grp_t push_data_i,
  output logic            pop_valid_o,
  input  logic            pop_i,
  output b64se_pkg::grp_t pop_data_o
);
  import b64se_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  grp_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== src/b64se_back.sv =====
// output side: turns one group into four characters, one per cycle while the receiver is ready
// depends on b64se_pkg
`timescale 1ns / 1ps

module b64se_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            pop_valid_i,
  output logic            pop_o,
  input  b64se_pkg::grp_t pop_data_i,
  output logic            m_tvalid_o,
  input  logic            m_tready_i,
  output logic [7:0]      m_tdata_o,
  output logic            m_tlast_o,
  output logic            m_tuser_o
);
  import b64se_pkg::*;

  grp_t       grp_q;
  logic       busy_q;
  logic [1:0] idx_q;
  logic       m_valid_q;
  logic [7:0] m_data_q;
  logic       m_last_q, m_user_q;
  logic       load;
  logic [5:0] sextet;
  logic       pad;
  logic [7:0] ch;

  assign load  = busy_q && (!m_valid_q || m_tready_i);
  assign pop_o = pop_valid_i && (!busy_q || (load && idx_q == 2'd3));

  always_comb begin
    case (idx_q)
      2'd0:    sextet = grp_q.bits24[23:18];
      2'd1:    sextet = grp_q.bits24[17:12];
      2'd2:    sextet = grp_q.bits24[11:6];
      default: sextet = grp_q.bits24[5:0];
    endcase
    pad = ((idx_q == 2'd2) && (grp_q.present < 2'd2)) ||
          ((idx_q == 2'd3) && (grp_q.present < 2'd3));
    ch  = pad ? PadChar : b64_char(sextet);
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      grp_q <= pop_data_i;
    end
    if (load) begin
      m_data_q <= ch;
      m_last_q <= (idx_q == 2'd3);
      m_user_q <= (idx_q == 2'd3) && grp_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      idx_q     <= 2'd0;
      m_valid_q <= 1'b0;
    end else begin
      if (load) begin
        m_valid_q <= 1'b1;
        idx_q     <= idx_q + 2'd1;
      end else if (m_tready_i) begin
        m_valid_q <= 1'b0;
      end
      if (pop_o) begin
        busy_q <= 1'b1;
      end else if (load && idx_q == 2'd3) begin
        busy_q <= 1'b0;
      end
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;
  assign m_tlast_o  = m_last_q;
  assign m_tuser_o  = m_user_q;

endmodule

// ===== src/base64_stream_encoder.sv =====
// base64 stream encoder top level: front, group queue and back
// depends on b64se_pkg, b64se_front, b64se_queue, b64se_back
`timescale 1ns / 1ps
//
// usage
//   input channel s_*: one raw byte per item in s_tdata_i, s_tlast_i marks
//   the last byte of a message
//   output channel m_*: one ascii character per item in m_tdata_o,
//   m_tlast_o on the fourth character of every group, m_tuser_o on the
//   fourth character of the group that ends the message; short final
//   groups are padded with '='
// timing
//   after the byte that finished a group is taken, the group passes the group
//   queue and the group register, and its first character then becomes valid
//   in the output register; the rest follow one character per cycle while
//   the receiver is ready, a rate set by the output register; the input keeps
//   taking bytes while the back still emits earlier groups
//   s_tready_o drops only while the QueueDepth group queue is full
// reset
//   held bytes, queue and output register are emptied; no item is pending
// stall
//   a stalled receiver holds the current character; the back stops, then
//   the queue fills, then s_tready_o goes low
//
module base64_stream_encoder #(
  parameter int unsigned QueueDepth = b64se_pkg::QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_tvalid_i,
  output logic       s_tready_o,
  input  logic [7:0] s_tdata_i,   // data_byte
  input  logic       s_tlast_i,
  output logic       m_tvalid_o,
  input  logic       m_tready_i,
  output logic [7:0] m_tdata_o,   // out_char
  output logic       m_tlast_o,
  output logic       m_tuser_o    // message_end
);
  import b64se_pkg::*;

  logic push_valid, push_ready, pop_valid, pop;
  grp_t push_data, pop_data;

  b64se_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_tvalid_i),
    .s_tready_o   (s_tready_o),
    .s_tdata_i    (s_tdata_i),
    .s_tlast_i    (s_tlast_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  b64se_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_data_o   (pop_data)
  );

  b64se_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_o       (pop),
    .pop_data_i  (pop_data),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o),
    .m_tlast_o   (m_tlast_o),
    .m_tuser_o   (m_tuser_o)
  );

endmodule

// ===== src/b64se_checker.sv =====
// port level checks for the base64 stream encoder, bound to the top level
// depends on b64se_pkg and base64_stream_encoder
`timescale 1ns / 1ps

module b64se_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_tvalid_i,
  input logic       m_tready_i,
  input logic [7:0] m_tdata_i,
  input logic       m_tlast_i,
  input logic       m_tuser_i
);
  import b64se_pkg::*;

  logic [1:0] pos_q;

  // position of the next output item within its group
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 2'd0;
    end else if (m_tvalid_i && m_tready_i) begin
      pos_q <= pos_q + 2'd1;
    end
  end

  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i |-> (m_tlast_i == (pos_q == 2'd3)))
    else $error("tlast not on fourth character");

  a_user_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_i && m_tuser_i) |-> m_tlast_i)
    else $error("message end off group end");

  a_no_early_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_i && pos_q < 2'd2) |-> (m_tdata_i != PadChar))
    else $error("padding in first two characters");

  a_pad_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_i && m_tready_i && m_tdata_i == PadChar && !m_tlast_i)
    |=> (m_tvalid_i && m_tdata_i == PadChar))
    else $error("third pad not followed by fourth pad");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_i && !m_tready_i) |=> (m_tvalid_i && $stable(m_tdata_i)))
    else $error("stalled output changed");

endmodule

bind base64_stream_encoder b64se_checker u_b64se_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .m_tvalid_i (m_tvalid_o),
  .m_tready_i (m_tready_i),
  .m_tdata_i  (m_tdata_o),
  .m_tlast_i  (m_tlast_o),
  .m_tuser_i  (m_tuser_o)
);

// ===== sim/base64_stream_encoder_tb.sv =====
// self-checking testbench for base64_stream_encoder: byte stream in, base64 characters out
// predicts each group's characters from its own alphabet table and checks them in order
// depends on b64se_pkg and base64_stream_encoder
`timescale 1ns / 1ps

module base64_stream_encoder_tb;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned RandomBytes = 74;
  localparam logic [511:0] AlphabetBits =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    logic [7:0] ch;
    logic       group_end;
    logic       msg_end;
  } enc_char_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;
  logic       m_tuser;

  enc_char_t   pending_chars[$];
  logic [15:0] held_bytes = '0;
  logic [1:0]  held_count = '0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned tx_idle_pct = 27;
  int unsigned rx_idle_pct = 27;
  int unsigned rx_hold_left = 0;

  base64_stream_encoder u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid),
    .s_tready_o (s_tready),
    .s_tdata_i  (s_tdata),     // data_byte
    .s_tlast_i  (s_tlast),
    .m_tvalid_o (m_tvalid),
    .m_tready_i (m_tready),
    .m_tdata_o  (m_tdata),     // out_char
    .m_tlast_o  (m_tlast),
    .m_tuser_o  (m_tuser)      // message_end
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // encoder state update for one accepted byte; queues four characters when a group closes
  task automatic encode_byte(input logic [7:0] b, input logic is_last);
    int unsigned present;
    logic [23:0] grp;
    logic [5:0]  sextet;
    enc_char_t   c;
    present = int'(held_count) + 1;
    if (present < 3 && !is_last) begin
      held_bytes = {held_bytes[7:0], b};
      held_count = 2'(present);
      return;
    end
    case (held_count)
      2'd0: grp = {b, 16'h0000};
      2'd1: grp = {held_bytes[7:0], b, 8'h00};
      default: begin
        grp = {held_bytes, b};
        present = 3;
      end
    endcase
    for (int k = 0; k < 4; k++) begin
      sextet = grp[23 - 6 * k -: 6];
      if ((k == 2 && present < 2) || (k == 3 && present < 3)) begin
        c.ch = b64se_pkg::PadChar;
      end else begin
        c.ch = AlphabetBits[(63 - int'(sextet)) * 8 +: 8];
      end
      c.group_end = (k == 3);
      c.msg_end = (k == 3) && is_last;
      pending_chars.push_back(c);
    end
    held_bytes = '0;
    held_count = '0;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic is_last);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata <= 8'($urandom);
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= is_last;
    do @(posedge clk_i); while (!s_tready);
    encode_byte(b, is_last);
  endtask

  // receiver: check each accepted character, then decide readiness for the next cycle
  always @(posedge clk_i) begin
    enc_char_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      if (pending_chars.size() == 0) begin
        mismatches++;
        $display("%0t: expected no character actual %h last %b user %b", $time, m_tdata,
                 m_tlast, m_tuser);
      end else begin
        want = pending_chars.pop_front();
        if (m_tdata !== want.ch) begin
          mismatches++;
          $display("%0t: char expected %h actual %h", $time, want.ch, m_tdata);
        end
        if (m_tlast !== want.group_end) begin
          mismatches++;
          $display("%0t: group end expected %b actual %b", $time, want.group_end, m_tlast);
        end
        if (m_tuser !== want.msg_end) begin
          mismatches++;
          $display("%0t: message end expected %b actual %b", $time, want.msg_end, m_tuser);
        end
      end
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic send_message(input int unsigned len);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(5))
        0: b = 8'h00;
        1: b = 8'hFF;
        default: b = 8'($urandom);
      endcase
      send_byte(b, i == len - 1);
    end
  endtask

  // one byte and two byte messages, padded with one or two pad characters
  task automatic test_short_messages();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  // last byte closing a full group, plus groups completed mid-message and a short final group
  task automatic test_full_groups();
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h4D, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h6E, 1'b0);
    send_byte(8'hFB, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b1);
  endtask

  task automatic test_random_messages();
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < RandomBytes) begin
      if (sent >= 20 && sent < 55) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else begin
        tx_idle_pct = 27;
        rx_idle_pct = 27;
      end
      len = $urandom_range(1, 8);
      send_message(len);
      sent += len;
    end
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_hold_left = 80;
    send_message(7);
    send_message(9);
    tx_idle_pct = 27;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_short_messages();
    test_full_groups();
    test_backpressure();
    test_random_messages();
    s_tvalid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
